### rtl/core/hgt_pkg.sv
// Shared types and constants of the hourglass timer controller.
// Used by the controller, the datapath, the divider and the top level.
package hgt_pkg;

    // Operating modes
    localparam logic [1:0] MODE_SLEEP  = 2'd0;
    localparam logic [1:0] MODE_ADJUST = 2'd1;
    localparam logic [1:0] MODE_COUNT  = 2'd2;

    // Orientation codes
    localparam logic [1:0] OR_UP        = 2'd0;
    localparam logic [1:0] OR_DOWN      = 2'd1;
    localparam logic [1:0] OR_SIDE_UP   = 2'd2;
    localparam logic [1:0] OR_SIDE_DOWN = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_TILT_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_ENC_STEP_TICKS = 3'd1;
    localparam logic [2:0] CFG_SLEEP_AFTER_MS = 3'd2;
    localparam logic [2:0] CFG_MIN_QUARTERS   = 3'd3;
    localparam logic [2:0] CFG_MAX_QUARTERS   = 3'd4;
    localparam logic [2:0] CFG_REFRESH_MS     = 3'd5;

    // Register reset values
    localparam logic [14:0] RST_TILT_THRESHOLD = 15'd3341;
    localparam logic [7:0]  RST_ENC_STEP_TICKS = 8'd4;
    localparam logic [31:0] RST_SLEEP_AFTER_MS = 32'd10000;
    localparam logic [5:0]  RST_MIN_QUARTERS   = 6'd1;
    localparam logic [5:0]  RST_MAX_QUARTERS   = 6'd20;
    localparam logic [15:0] RST_REFRESH_MS     = 16'd20;
    localparam logic [5:0]  RST_DURATION       = 6'd2;

    // Time constants
    localparam int          TOTAL_W        = 20;
    localparam logic [19:0] MS_PER_QUARTER = 20'd15000;
    localparam logic [19:0] MS_PER_BLINK   = 20'd1000;
    localparam logic [19:0] BLINK_HALF     = 20'd500;

    // ceil(2^38 / 1000): (now * BLINK_RECIP) >> 38 is now / 1000 for any 32-bit now
    localparam logic [28:0] BLINK_RECIP    = 29'd274877907;

    // Stream widths
    localparam int IN_W  = 96;
    localparam int OUT_W = 16;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic eval;
        logic commit;
        logic div_start;
        logic load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/hourglass_timer_controller.sv
// Hourglass timer controller top level: sequencer plus datapath.
// Uses hgt_pkg; instantiates hgt_ctrl and hgt_dp.
//
// Usage: each input transaction is one sample (time stamp, accelerometer x/y,
// encoder count); each one yields exactly one result transaction with mode,
// orientation flag, duration and countdown progress.
// Configuration: write i_cfg_data to register i_cfg_index with i_cfg_wr_en,
// only while no sample is in flight. Indexes: 0 tilt threshold, 1 encoder
// step ticks, 2 sleep time, 3 min quarters, 4 max quarters, 5 refresh period.
// Timing: one sample at a time. The result is offered from the output register
// after the evaluate, commit, divider check and done states, and the next sample
// can be taken once the sequencer is back in idle. A countdown progress update
// before time up adds the run of the two-bit-per-cycle progress divider; a
// time-up update adds nothing, as now mod 1000 comes from a reciprocal multiply
// in the evaluate and commit cycles.
// Stall: the result sits in an output register; the next sample is taken
// while it waits, and that sample finishes once the register is free.
// Reset: synchronous active low; registers return to their defaults, the timer
// starts in adjust mode with a duration of two quarter minutes.
module hourglass_timer_controller import hgt_pkg::*; #(
    parameter int SAND_ROWS = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // [31:0] now_ms, [47:32] accel_x, [63:48] accel_y, [95:64] enc_count
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // [1:0] mode, [2] facing_up, [8:3] duration_quarters, [9] frame_refresh,
    // [10] time_up, [11] blink_on, [14:12] sand_lines, [15] zero
    output logic [OUT_W-1:0] o_m_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    hgt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    hgt_dp #(
        .SAND_ROWS (SAND_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    // Only one sample in flight: ready drops right after a transaction
    a_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while a sample is in flight");

    // A started divider run is busy on the next cycle
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> w_stat.div_busy)
        else $error("divider did not start");

    // A loaded result is offered on the next cycle
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_m_tvalid)
        else $error("loaded result not offered");

    // Never load over a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !w_cmd.load_out)
        else $error("pending result overwritten");

endmodule

### rtl/core/hgt_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Uses hgt_pkg for widths; instantiated by the datapath.
module hgt_div import hgt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_num,    // dividend bits still to shift in, MSB first
    input  logic [TOTAL_W-1:0]   i_rem,    // initial partial remainder, below i_den
    input  logic [TOTAL_W-1:0]   i_den,
    input  logic [4:0]           i_steps,
    output logic                 o_busy,
    output logic [31:0]          o_quo     // quotient bits collect at the LSB end
);

    logic [4:0]         r_cnt;
    logic [31:0]        r_sh;
    logic [TOTAL_W-1:0] r_rem;
    logic [TOTAL_W-1:0] r_den;
    logic [31:0]        n_sh;
    logic [TOTAL_W-1:0] n_rem;

    // Two shift-compare-subtract steps
    always_comb begin
        logic [TOTAL_W:0] w_try;
        logic             w_ge;
        n_sh  = r_sh;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            w_try = {n_rem, n_sh[31]};
            w_ge  = (w_try >= {1'b0, r_den});
            n_rem = w_ge ? TOTAL_W'(w_try - {1'b0, r_den}) : TOTAL_W'(w_try);
            n_sh  = {n_sh[30:0], w_ge};
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // Operand registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_num;
            r_rem <= i_rem;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_sh  <= n_sh;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_sh;

endmodule

### rtl/core/hgt_ctrl.sv
// Sequencing state machine of the hourglass timer controller.
// Uses hgt_pkg command and status types; drives the datapath.
module hgt_ctrl import hgt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_COMMIT = 3'd2;
    localparam logic [2:0] ST_DIVGO  = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_DIVGO;
            end
            ST_DIVGO: begin
                if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (!i_stat.div_busy) n_state = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.load_out = i_stat.out_free;
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

endmodule

### rtl/core/hgt_dp.sv
// Datapath of the hourglass timer controller: registers, timer state,
// evaluation and commit logic, progress divider and output register.
// Uses hgt_pkg and instantiates hgt_div.
module hgt_dp import hgt_pkg::*; #(
    parameter int SAND_ROWS = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [OUT_W-1:0] o_m_tdata,
    input  t_cmd             i_cmd,
    output t_stat            o_stat
);

    localparam int          QUO_W      = $clog2(SAND_ROWS + 1);
    localparam int          QUO_W2     = QUO_W + (QUO_W % 2);
    localparam logic [4:0]  SAND_STEPS = 5'(QUO_W2 / 2);
    localparam logic [3:0]  SAND_K     = 4'(SAND_ROWS);
    localparam logic [2:0]  SAND_FULL  = 3'(SAND_ROWS);

    // Configuration registers
    logic [14:0] r_tilt;
    logic [7:0]  r_step;
    logic [31:0] r_sleep;
    logic [5:0]  r_minq;
    logic [5:0]  r_maxq;
    logic [15:0] r_refr;

    // Captured sample
    logic [31:0]        r_now;
    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [31:0] r_enc;

    // Timer state; the previous orientation always equals r_orient between items
    logic [1:0]         r_mode;
    logic [1:0]         r_orient;
    logic               r_primed;
    logic [31:0]        r_act_mark;
    logic [5:0]         r_dur;
    logic [31:0]        r_cnt_start;
    logic [31:0]        r_ref_mark;
    logic signed [31:0] r_enc_ref;

    // Evaluation stage
    logic [1:0]          r_orient_nx;
    logic signed [32:0]  r_diff;
    logic                r_due;
    logic                r_idle;
    logic [31:0]         r_elapsed;
    logic [TOTAL_W-1:0]  r_total;

    // Commit results
    logic               r_res_refresh;
    logic               r_res_up;
    logic [TOTAL_W-1:0] r_res_elap;

    // Now mod 1000 for the blink: reciprocal multiply, then multiply back and subtract
    logic [60:0]        w_blink_prod;
    logic [31:0]        w_blink_back;
    logic [31:0]        w_now_mod;
    logic [22:0]        r_blink_q;
    logic [9:0]         r_now_mod;

    // Output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // Commit next values
    logic [1:0]         n_mode;
    logic [31:0]        n_act_mark;
    logic [5:0]         n_dur;
    logic [31:0]        n_cnt_start;
    logic [31:0]        n_ref_mark;
    logic signed [31:0] n_enc_ref;
    logic               n_refresh;
    logic               n_up;
    logic [31:0]        n_elap;

    // Classification
    logic [1:0]         w_orient_cls;
    logic signed [16:0] w_thr;
    logic signed [16:0] w_ax;
    logic signed [16:0] w_ay;

    // Divider hookup
    logic [23:0]        w_sand_num;
    logic [31:0]        w_div_num;
    logic [TOTAL_W-1:0] w_div_rem_in;
    logic [TOTAL_W-1:0] w_div_den;
    logic [4:0]         w_div_steps;
    logic               w_div_busy;
    logic [31:0]        w_div_quo;

    logic               w_out_free;
    logic               w_blink;
    logic [2:0]         w_lines;
    logic               w_face;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt  <= RST_TILT_THRESHOLD;
            r_step  <= RST_ENC_STEP_TICKS;
            r_sleep <= RST_SLEEP_AFTER_MS;
            r_minq  <= RST_MIN_QUARTERS;
            r_maxq  <= RST_MAX_QUARTERS;
            r_refr  <= RST_REFRESH_MS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TILT_THRESHOLD: r_tilt  <= i_cfg_data[14:0];
                CFG_ENC_STEP_TICKS: r_step  <= i_cfg_data[7:0];
                CFG_SLEEP_AFTER_MS: r_sleep <= i_cfg_data;
                CFG_MIN_QUARTERS:   r_minq  <= i_cfg_data[5:0];
                CFG_MAX_QUARTERS:   r_maxq  <= i_cfg_data[5:0];
                CFG_REFRESH_MS:     r_refr  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Capture the sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_s_tdata[31:0];
            r_ax  <= i_s_tdata[47:32];
            r_ay  <= i_s_tdata[63:48];
            r_enc <= i_s_tdata[95:64];
        end
    end

    // Classify orientation, hold it inside the dead band
    always_comb begin
        w_thr = $signed({2'b00, r_tilt});
        w_ax  = {r_ax[15], r_ax};
        w_ay  = {r_ay[15], r_ay};
        if (w_ay > w_thr)       w_orient_cls = OR_UP;
        else if (w_ay < -w_thr) w_orient_cls = OR_DOWN;
        else if (w_ax > w_thr)  w_orient_cls = OR_SIDE_DOWN;
        else if (w_ax < -w_thr) w_orient_cls = OR_SIDE_UP;
        else                    w_orient_cls = r_orient;
    end

    // Quotient of now by 1000 in the evaluation cycle, remainder in the commit cycle
    assign w_blink_prod = {29'd0, r_now} * {32'd0, BLINK_RECIP};
    assign w_blink_back = {9'd0, r_blink_q} * {12'd0, MS_PER_BLINK};
    assign w_now_mod    = r_now - w_blink_back;

    // Evaluation stage: wide adds, compares and multiplies, one register per term
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_orient_nx <= w_orient_cls;
            r_diff      <= {r_enc[31], r_enc} - {r_enc_ref[31], r_enc_ref};
            r_due       <= r_now > (r_ref_mark + {16'd0, r_refr});
            r_idle      <= (r_now - r_act_mark) > r_sleep;
            r_elapsed   <= r_now - r_cnt_start;
            r_total     <= TOTAL_W'({14'd0, r_dur} * MS_PER_QUARTER);
            r_blink_q   <= w_blink_prod[60:38];
        end
    end

    // Mode logic of one sample
    always_comb begin
        logic               w_flip;
        logic               w_moved;
        logic               w_dir_up;
        logic               w_vert;
        logic               w_idle;
        logic               w_mark;
        logic signed [32:0] w_step;
        logic [6:0]         w_sum;
        logic [6:0]         w_lo;
        logic [6:0]         w_hi;

        w_flip   = r_primed && (r_orient_nx != r_orient);
        w_step   = (r_step == 8'd0) ? 33'sd1 : $signed({25'd0, r_step});
        w_moved  = (r_diff >= w_step) || (r_diff <= -w_step);
        w_dir_up = !r_diff[32] && (r_diff != 33'sd0);
        w_vert   = (r_orient_nx == OR_UP) || (r_orient_nx == OR_DOWN);
        w_idle   = r_idle && r_primed && !w_flip && !w_moved;
        w_mark   = !r_primed || w_flip;
        w_lo     = (r_minq == 6'd0) ? 7'd1 : {1'b0, r_minq};
        w_hi     = (r_maxq == 6'd0) ? 7'd1 : {1'b0, r_maxq};
        w_sum    = w_dir_up ? ({1'b0, r_dur} + 7'd1) : ({1'b0, r_dur} - 7'd1);
        if (w_sum < w_lo) w_sum = w_lo;
        if (w_sum > w_hi) w_sum = w_hi;

        n_mode      = r_mode;
        n_dur       = r_dur;
        n_cnt_start = r_cnt_start;
        n_ref_mark  = r_ref_mark;
        n_enc_ref   = r_enc_ref;
        n_refresh   = 1'b0;
        n_elap      = w_flip ? 32'd0 : r_elapsed;
        n_up        = n_elap >= {12'd0, r_total};

        case (r_mode)
            MODE_SLEEP: begin
                if (!w_idle || w_moved) begin
                    w_mark = 1'b1;
                    n_mode = MODE_ADJUST;
                end
            end
            MODE_ADJUST: begin
                if (w_moved) begin
                    w_mark    = 1'b1;
                    n_enc_ref = r_enc;
                    n_dur     = w_sum[5:0];
                end
                if (w_flip) begin
                    if (w_vert) begin
                        n_cnt_start = r_now;
                        n_mode      = MODE_COUNT;
                    end
                end else if (w_idle) begin
                    n_mode = MODE_SLEEP;
                end
            end
            MODE_COUNT: begin
                if (w_moved) begin
                    w_mark = 1'b1;
                    n_mode = MODE_ADJUST;
                end
                if (w_flip) begin
                    if (!w_vert) n_mode = MODE_ADJUST;
                    n_cnt_start = r_now;
                end
                if (r_due) begin
                    n_ref_mark = r_now;
                    n_refresh  = 1'b1;
                    if (n_up) begin
                        if (w_idle) n_mode = MODE_SLEEP;
                    end else begin
                        w_mark = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        n_act_mark = w_mark ? r_now : r_act_mark;
    end

    // Commit timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ADJUST;
            r_orient    <= OR_UP;
            r_primed    <= 1'b0;
            r_act_mark  <= '0;
            r_dur       <= RST_DURATION;
            r_cnt_start <= '0;
            r_ref_mark  <= '0;
            r_enc_ref   <= '0;
        end else if (i_cmd.commit) begin
            r_mode      <= n_mode;
            r_orient    <= r_orient_nx;
            r_primed    <= 1'b1;
            r_act_mark  <= n_act_mark;
            r_dur       <= n_dur;
            r_cnt_start <= n_cnt_start;
            r_ref_mark  <= n_ref_mark;
            r_enc_ref   <= n_enc_ref;
        end
    end

    // Hold the per-sample results for the divider and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_refresh <= 1'b0;
        end else if (i_cmd.commit) begin
            r_res_refresh <= n_refresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_up   <= n_up;
            r_res_elap <= n_elap[TOTAL_W-1:0];
            r_now_mod  <= w_now_mod[9:0];
        end
    end

    // Divider operands: SAND_ROWS*elapsed/total, low dividend bits shifted in last
    always_comb begin
        w_sand_num   = {20'd0, SAND_K} * {4'd0, r_res_elap};
        w_div_num    = {8'd0, w_sand_num} << (32 - QUO_W2);
        w_div_rem_in = TOTAL_W'(w_sand_num >> QUO_W2);
        w_div_den    = r_total;
        w_div_steps  = SAND_STEPS;
    end

    hgt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_rem   (w_div_rem_in),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_busy  (w_div_busy),
        .o_quo   (w_div_quo)
    );

    // Assemble the result
    assign w_face  = (r_orient == OR_UP) || (r_orient == OR_SIDE_UP);
    assign w_blink = r_res_refresh && r_res_up && ({10'd0, r_now_mod} > BLINK_HALF);
    assign w_lines = !r_res_refresh ? 3'd0 :
                     r_res_up       ? SAND_FULL : 3'(w_div_quo[QUO_W2-1:0]);

    // Output register
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {1'b0, w_lines, w_blink, r_res_up && r_res_refresh,
                           r_res_refresh, r_dur, w_face, r_mode};
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_data;
    assign o_stat.need_div = r_res_refresh && !r_res_up;
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_free = w_out_free;

endmodule
